/* rtl/core/dq_pkg.sv */
// ----------------------------------------------------------------------------
// Double-ended queue package
// Operation codes, status codes, field widths and the stage record shared by
// the queue's files.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int KIND_W   = 3;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_FRONT = 3'd0,
		KIND_PUSH_BACK  = 3'd1,
		KIND_POP_FRONT  = 3'd2,
		KIND_POP_BACK   = 3'd3,
		KIND_PEEK_FRONT = 3'd4,
		KIND_PEEK_BACK  = 3'd5,
		KIND_CLEAR      = 3'd6
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_DATA = 2'd1,
		ST_ERR  = 2'd2
	} status_t;

	// What the read stage keeps of an operation while the memory answers.
	typedef struct packed {
		status_t            status;
		logic               rd;
		logic [COUNT_W-1:0] count;
	} s1_t;

endpackage

/* rtl/core/dq_cmd_if.sv */
// ----------------------------------------------------------------------------
// Double-ended queue command channel
// Valid/ready channel carrying one queue operation per transaction.
// ----------------------------------------------------------------------------
interface dq_cmd_if import dq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

/* rtl/core/dq_rsp_if.sv */
// ----------------------------------------------------------------------------
// Double-ended queue response channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface dq_rsp_if import dq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic signed [DATA_W-1:0] data;
	logic [COUNT_W-1:0]       count;

	modport source (output valid, output status, output data, output count, input ready);
	modport sink   (input valid, input status, input data, input count, output ready);
endinterface

/* rtl/core/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit words kept as a ring buffer in one RAM.
// ----------------------------------------------------------------------------
// Usage: each transaction on the cmd channel is one operation: push at the
// front or back, pop or peek at the front or back, or clear. Every operation
// yields exactly one transaction on the rsp channel carrying a status (ok,
// data or error), the popped or peeked word (zero unless the status is data)
// and the number of stored words after the operation.
// Pops and peeks on an empty queue, and pushes on a full one, report an error
// and leave the queue as it was. Codes with no meaning are answered with ok.
// A command passes the read stage and the output register before its result is
// valid; one command is taken per cycle unless the receiver stalls, as each
// operation needs at most one RAM access (a push writes, a pop or peek reads).
// The front index and the occupancy are updated when the command is taken, so
// a following operation always sees the up-to-date pointers, and a read in the
// cycle after a write to the same entry finds the new word in the RAM.
// Reset empties the queue at once; the RAM contents are not cleared and no
// clearing pass is needed. When the receiver stalls, the result waits in the
// output register, one more result waits in the read stage, and cmd.ready
// drops only once both are full.
// ----------------------------------------------------------------------------
module double_ended_queue import dq_pkg::*; #(
	parameter int CAPACITY = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	dq_cmd_if.sink   cmd,
	dq_rsp_if.source rsp
);

	// Index into the ring, occupancy (which may reach CAPACITY) and a sum of both.
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OW = $clog2(CAPACITY + 1);
	localparam int SW = OW + 1;

	// Pointer state.
	logic [IW-1:0] front_q;
	logic [OW-1:0] occ_q;

	// Read stage and output register.
	logic                     s1_valid_s1;
	s1_t                      s1_s1;
	logic                     out_valid_q;
	logic [STATUS_W-1:0]      out_status_q;
	logic signed [DATA_W-1:0] out_data_q;
	logic [COUNT_W-1:0]       out_count_q;

	// Decode of the command in flight.
	logic          acc;
	logic          out_free;
	logic          full;
	logic          empty;
	logic [IW-1:0] front_dec;
	logic [IW-1:0] front_inc;
	logic [SW-1:0] tail_sum;
	logic [SW-1:0] back_sum;
	logic [IW-1:0] tail_slot;
	logic [IW-1:0] back_slot;
	logic [IW-1:0] front_nxt;
	logic [OW-1:0] occ_nxt;
	logic          ram_we;
	logic          ram_re;
	logic [IW-1:0] ram_addr;
	logic [DATA_W-1:0] ram_rdata;
	s1_t           s1_nxt;

	assign acc      = cmd.valid && cmd.ready;
	assign out_free = !out_valid_q || rsp.ready;
	// The read stage may take a new command whenever it can pass its own on.
	assign cmd.ready = !s1_valid_s1 || out_free;

	assign full  = (occ_q == OW'(CAPACITY));
	assign empty = (occ_q == '0);

	// Ring arithmetic: the sums stay below twice the capacity, so one
	// compare and subtract brings them back into range.
	assign front_dec = (front_q == '0) ? IW'(CAPACITY - 1) : front_q - IW'(1);
	assign front_inc = (front_q == IW'(CAPACITY - 1)) ? '0 : front_q + IW'(1);
	assign tail_sum  = SW'(front_q) + SW'(occ_q);
	assign back_sum  = tail_sum - SW'(1);
	assign tail_slot = (tail_sum >= SW'(CAPACITY)) ? IW'(tail_sum - SW'(CAPACITY))
	                                               : IW'(tail_sum);
	assign back_slot = (back_sum >= SW'(CAPACITY)) ? IW'(back_sum - SW'(CAPACITY))
	                                               : IW'(back_sum);

	always_comb begin
		front_nxt     = front_q;
		occ_nxt       = occ_q;
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		ram_addr      = front_q;
		s1_nxt.status = ST_OK;
		s1_nxt.rd     = 1'b0;
		unique case (cmd.kind)
			KIND_PUSH_FRONT: begin
				if (full) begin
					s1_nxt.status = ST_ERR;
				end else begin
					front_nxt = front_dec;
					occ_nxt   = occ_q + OW'(1);
					ram_we    = acc;
					ram_addr  = front_dec;
				end
			end
			KIND_PUSH_BACK: begin
				if (full) begin
					s1_nxt.status = ST_ERR;
				end else begin
					occ_nxt  = occ_q + OW'(1);
					ram_we   = acc;
					ram_addr = tail_slot;
				end
			end
			KIND_POP_FRONT, KIND_PEEK_FRONT: begin
				if (empty) begin
					s1_nxt.status = ST_ERR;
				end else begin
					s1_nxt.status = ST_DATA;
					s1_nxt.rd     = 1'b1;
					ram_re        = acc;
					ram_addr      = front_q;
					if (cmd.kind == KIND_POP_FRONT) begin
						front_nxt = front_inc;
						occ_nxt   = occ_q - OW'(1);
					end
				end
			end
			KIND_POP_BACK, KIND_PEEK_BACK: begin
				if (empty) begin
					s1_nxt.status = ST_ERR;
				end else begin
					s1_nxt.status = ST_DATA;
					s1_nxt.rd     = 1'b1;
					ram_re        = acc;
					ram_addr      = back_slot;
					if (cmd.kind == KIND_POP_BACK) begin
						occ_nxt = occ_q - OW'(1);
					end
				end
			end
			KIND_CLEAR: begin
				front_nxt = '0;
				occ_nxt   = '0;
			end
			default: begin
				// Codes without meaning leave everything as it is.
			end
		endcase
		s1_nxt.count = COUNT_W'(occ_nxt);
	end

	dq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (DATA_W'(cmd.value)),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	// Pointers move as soon as the command is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			occ_q   <= '0;
		end else if (acc) begin
			front_q <= front_nxt;
			occ_q   <= occ_nxt;
		end
	end

	// Read stage: holds the operation while the RAM's registered read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			s1_valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_s1 <= s1_nxt;
		end
	end

	// Output register: the RAM's read data holds until the next read, and no
	// read is issued while the read stage is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_valid_s1) begin
			out_status_q <= s1_s1.status;
			out_data_q   <= s1_s1.rd ? ram_rdata : '0;
			out_count_q  <= s1_s1.count;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.data   = out_data_q;
	assign rsp.count  = out_count_q;

`ifndef SYNTH
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(CAPACITY))
		else $error("occupancy exceeds capacity");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= IW'(CAPACITY - 1))
		else $error("front index out of range");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		acc && full && (cmd.kind == KIND_PUSH_FRONT || cmd.kind == KIND_PUSH_BACK)
		|=> $stable(occ_q) && $stable(front_q))
		else $error("push on a full queue changed the pointers");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd.kind == KIND_CLEAR |=> occ_q == '0 && front_q == '0)
		else $error("clear did not empty the queue");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_DATA |-> rsp.data == '0)
		else $error("non-zero data on a result without data");
`endif

endmodule

/* rtl/core/dq_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port with a registered read; read data holds
// until the next read.
// ----------------------------------------------------------------------------
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
